// File: src/rarhdr_pkg.sv
// Shared types, constants and helpers for the archive signature and main header parser.
package rarhdr_pkg;

  localparam int unsigned POS_W    = 32;  // byte position counter width
  localparam int unsigned CFG_W    = 32;  // max_search_bytes register width
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned REL_W    = 5;   // saturating offset from marker start
  localparam int unsigned VIDX_W   = 4;
  localparam int unsigned FLAG_W   = 16;
  localparam int unsigned OUT_DATA_W = 48;

  localparam logic [CFG_W-1:0] MAX_SEARCH_RESET = 32'd1048576;

  // Offsets relative to the marker start
  localparam logic [REL_W-1:0] REL_MAX         = 5'd31;
  localparam logic [REL_W-1:0] REL_BODY4_FIRST = 5'd7;
  localparam logic [REL_W-1:0] REL_BODY5_FIRST = 5'd8;
  localparam logic [REL_W-1:0] REL_FLAG_LO     = 5'h0A;
  localparam logic [REL_W-1:0] REL_FLAG_HI     = 5'h0B;
  localparam logic [REL_W-1:0] REL_BODY4_END   = 5'd26;
  localparam logic [REL_W-1:0] REL_VARINT      = 5'd12;
  localparam logic [REL_W-1:0] REL_BODY5_END   = 5'd15;
  localparam logic [REL_W-1:0] REL_BODY5_FULL  = 5'd16;

  localparam logic [VIDX_W-1:0] VIDX_TOP_BIT = 4'd9;   // byte carrying bit 63
  localparam logic [VIDX_W-1:0] VIDX_MAX     = 4'd15;

  localparam logic [BYTE_W-1:0] VER_BYTE_4  = 8'h00;
  localparam logic [BYTE_W-1:0] VER_BYTE_5  = 8'h01;
  localparam logic [BYTE_W-1:0] ZERO_BYTE   = 8'h00;

  localparam logic [FLAG_W-1:0] HDR_TYPE_MAIN = 16'd1;
  localparam logic [FLAG_W-1:0] HDR_TYPE_ENC  = 16'd4;

  // Result codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_INVALID   = 2'd1;
  localparam logic [1:0] ST_ENCRYPTED = 2'd2;

  localparam logic [2:0] VER_NONE = 3'd0;
  localparam logic [2:0] VER_4    = 3'd4;
  localparam logic [2:0] VER_5    = 3'd5;

  // Output tdata bit positions
  localparam int unsigned OD_STATUS = 0;
  localparam int unsigned OD_VER    = 2;
  localparam int unsigned OD_OFS    = 5;
  localparam int unsigned OD_SFX    = 37;
  localparam int unsigned OD_FLAGS  = 38;
  localparam int unsigned OD_USED   = 44;

  typedef enum logic [3:0] {
    PH_M0       = 4'd0,
    PH_M1       = 4'd1,
    PH_M2       = 4'd2,
    PH_M3       = 4'd3,
    PH_M4       = 4'd4,
    PH_M5       = 4'd5,
    PH_VER      = 4'd6,
    PH_V5_ZERO  = 4'd7,
    PH_BODY4    = 4'd8,
    PH_BODY5    = 4'd9
  } rarhdr_phase_e;

  typedef enum logic [2:0] {
    HF_SIZE    = 3'd0,
    HF_TYPE    = 3'd1,
    HF_HFLAGS  = 3'd2,
    HF_EXTRA   = 3'd3,
    HF_AFLAGS  = 3'd4,
    HF_DONE    = 3'd5,
    HF_INVALID = 3'd6,
    HF_ENC     = 3'd7
  } rarhdr_field_e;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              end_of_file;
  } rarhdr_item_t;

  // First member sits in the top bits, so status lands at bit 0.
  typedef struct packed {
    logic             first_vol;
    logic             hdr_encrypted;
    logic             has_recovery;
    logic             solid;
    logic             locked;
    logic             multivolume;
    logic             is_self_extracting;
    logic [POS_W-1:0] archive_offset;
    logic [2:0]       version;
    logic [1:0]       status;
  } rarhdr_result_t;

  function automatic logic [BYTE_W-1:0] sig_byte(input logic [2:0] idx);
    logic [BYTE_W-1:0] b;
    case (idx)
      3'd0:    b = 8'h52;
      3'd1:    b = 8'h61;
      3'd2:    b = 8'h72;
      3'd3:    b = 8'h21;
      3'd4:    b = 8'h1A;
      3'd5:    b = 8'h07;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// File: src/rar_signature_and_main_header_parser.sv
// Top level: archive signature search and main header parser on a byte stream.
//
// Slave stream: one file byte per transaction on s_axis_tdata_i, s_axis_tlast_i
// high on the last byte of a file. Master stream: exactly one result transaction
// per file, sent as soon as the outcome is fixed or at the end of data.
// cfg_we_i/cfg_wdata_i write max_search_bytes (reset 1048576); write it only while
// no file is in flight.
// Throughput: one byte per cycle unless a result stalls. Each byte sits in the input
// register while the parser decodes it, and its result (if any) is loaded from there
// into the output register, which drives m_axis.
// If the master side stalls, the pending result is held; the parser keeps
// consuming bytes that produce no result, and stops only when a second result
// would need the busy output register, at which point s_axis_tready_o drops once
// the input register fills. Reset clears all state and empties both registers.
module rar_signature_and_main_header_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,  // [7:0] data_byte
  input  logic        s_axis_tlast_i,  // end_of_file
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [1:0] status, [4:2] version, [36:5] archive_offset, [37] is_self_extracting,
  // [38] multivolume, [39] locked, [40] solid, [41] has_recovery,
  // [42] hdr_encrypted, [43] first_vol, [47:44] zero
  output logic [47:0] m_axis_tdata_o
);

  logic                       in_valid, step, out_free, res_valid;
  rarhdr_pkg::rarhdr_item_t   item;
  rarhdr_pkg::rarhdr_result_t res;

  // Parser step stalls only while a result is stuck in the output register.
  assign step = in_valid && (out_free || !res_valid);

  rarhdr_in_stage u_in (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .step_i          (step),
    .valid_o         (in_valid),
    .item_o          (item)
  );

  rarhdr_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (step),
    .item_i      (item),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  rarhdr_out_stage u_out (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (step && res_valid),
    .res_i           (res),
    .free_o          (out_free),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

endmodule

// File: src/rarhdr_in_stage.sv
// Input register: captures one byte transaction from the slave stream.
module rarhdr_in_stage (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  input  logic [7:0]               s_axis_tdata_i,   // [7:0] data_byte
  input  logic                     s_axis_tlast_i,   // end_of_file
  input  logic                     step_i,
  output logic                     valid_o,
  output rarhdr_pkg::rarhdr_item_t item_o
);

  logic                     valid_q, valid_d;
  rarhdr_pkg::rarhdr_item_t item_q, item_d;

  assign s_axis_tready_o = !valid_q || step_i;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (step_i) begin
      valid_d = 1'b0;
    end
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      valid_d           = 1'b1;
      item_d.data_byte  = s_axis_tdata_i;
      item_d.end_of_file = s_axis_tlast_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// File: src/rarhdr_parser.sv
// Per-file parser state: marker search, format 4/5 header fields, result decision.
module rarhdr_parser (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [31:0]                cfg_wdata_i,
  input  logic                       step_i,
  input  rarhdr_pkg::rarhdr_item_t   item_i,
  output logic                       res_valid_o,
  output rarhdr_pkg::rarhdr_result_t res_o
);

  logic [rarhdr_pkg::CFG_W-1:0]  msb_q;
  rarhdr_pkg::rarhdr_phase_e     phase_q, phase_d;
  logic [rarhdr_pkg::POS_W-1:0]  pos_q, pos_d, pos_nxt;
  logic [rarhdr_pkg::POS_W-1:0]  marker_q, marker_d;
  logic [rarhdr_pkg::FLAG_W-1:0] flag_q, flag_d;
  logic [rarhdr_pkg::FLAG_W-1:0] acc_lo_q, acc_lo_d;
  logic                          acc_hi_q, acc_hi_d;
  logic [rarhdr_pkg::VIDX_W-1:0] vidx_q, vidx_d;
  rarhdr_pkg::rarhdr_field_e     hfi_q, hfi_d;
  logic [rarhdr_pkg::REL_W-1:0]  rel_q, rel_d;
  logic                          sent_q, sent_d;

  logic [7:0]                    b;
  logic                          eof;
  logic                          pos_open, ex_en, limit_hit, in_body, hfi_open;
  logic [6:0]                    vdata;
  logic [rarhdr_pkg::FLAG_W-1:0] lo_add, v_lo;
  logic                          hi_add, v_hi, v_ovf;
  logic                          em_valid;
  logic [1:0]                    em_status;
  logic [2:0]                    em_ver;

  assign b   = item_i.data_byte;
  assign eof = item_i.end_of_file;

  // Position bookkeeping; the position saturates at all ones.
  assign pos_open  = ~&pos_q;
  assign pos_nxt   = pos_open ? pos_q + 1'b1 : pos_q;
  assign ex_en     = !sent_q && pos_open && (pos_q < msb_q);
  assign limit_hit = (pos_nxt >= msb_q) || (&pos_nxt);
  assign in_body   = (phase_q == rarhdr_pkg::PH_BODY4) || (phase_q == rarhdr_pkg::PH_BODY5);
  assign hfi_open  = (hfi_q == rarhdr_pkg::HF_SIZE) || (hfi_q == rarhdr_pkg::HF_TYPE) ||
                     (hfi_q == rarhdr_pkg::HF_HFLAGS) || (hfi_q == rarhdr_pkg::HF_EXTRA) ||
                     (hfi_q == rarhdr_pkg::HF_AFLAGS);

  // 7-bit continuation integer: only the low 16 bits and an upper-bits-nonzero flag matter.
  always_comb begin
    vdata  = b[6:0];
    lo_add = '0;
    hi_add = 1'b0;
    case (vidx_q)
      4'd0: lo_add = {9'd0, vdata};
      4'd1: lo_add = {2'd0, vdata, 7'd0};
      4'd2: begin
        lo_add = {vdata[1:0], 14'd0};
        hi_add = |vdata[6:2];
      end
      default: hi_add = |vdata;
    endcase
    v_ovf = ((vidx_q > rarhdr_pkg::VIDX_TOP_BIT) && (vdata != '0)) ||
            ((vidx_q == rarhdr_pkg::VIDX_TOP_BIT) && (vdata[6:1] != '0));
    v_lo  = acc_lo_q | lo_add;
    v_hi  = acc_hi_q | hi_add;
  end

  // Next state
  always_comb begin
    phase_d   = phase_q;
    pos_d     = pos_nxt;
    marker_d  = marker_q;
    flag_d    = flag_q;
    acc_lo_d  = acc_lo_q;
    acc_hi_d  = acc_hi_q;
    vidx_d    = vidx_q;
    hfi_d     = hfi_q;
    rel_d     = rel_q;
    sent_d    = sent_q;
    em_valid  = 1'b0;
    em_status = rarhdr_pkg::ST_INVALID;
    em_ver    = rarhdr_pkg::VER_NONE;

    if (in_body && pos_open && (rel_q != rarhdr_pkg::REL_MAX)) begin
      rel_d = rel_q + 1'b1;
    end

    if (ex_en) begin
      unique case (phase_q) inside
        rarhdr_pkg::PH_M0, rarhdr_pkg::PH_M1, rarhdr_pkg::PH_M2,
        rarhdr_pkg::PH_M3, rarhdr_pkg::PH_M4, rarhdr_pkg::PH_M5: begin
          if (b == rarhdr_pkg::sig_byte(phase_q[2:0])) begin
            if (phase_q == rarhdr_pkg::PH_M0) begin
              marker_d = pos_q;
            end
            phase_d = rarhdr_pkg::rarhdr_phase_e'(phase_q + 4'd1);
          end else if (b == rarhdr_pkg::sig_byte(3'd0)) begin
            phase_d  = rarhdr_pkg::PH_M1;
            marker_d = pos_q;
          end else begin
            phase_d = rarhdr_pkg::PH_M0;
          end
        end
        rarhdr_pkg::PH_VER: begin
          if (b == rarhdr_pkg::VER_BYTE_4) begin
            phase_d = rarhdr_pkg::PH_BODY4;
            flag_d  = '0;
            rel_d   = rarhdr_pkg::REL_BODY4_FIRST;
          end else if (b == rarhdr_pkg::VER_BYTE_5) begin
            phase_d = rarhdr_pkg::PH_V5_ZERO;
          end else if (b == rarhdr_pkg::sig_byte(3'd0)) begin
            phase_d  = rarhdr_pkg::PH_M1;
            marker_d = pos_q;
          end else begin
            phase_d = rarhdr_pkg::PH_M0;
          end
        end
        rarhdr_pkg::PH_V5_ZERO: begin
          if (b == rarhdr_pkg::ZERO_BYTE) begin
            phase_d  = rarhdr_pkg::PH_BODY5;
            hfi_d    = rarhdr_pkg::HF_SIZE;
            acc_lo_d = '0;
            acc_hi_d = 1'b0;
            vidx_d   = '0;
            rel_d    = rarhdr_pkg::REL_BODY5_FIRST;
          end else if (b == rarhdr_pkg::sig_byte(3'd0)) begin
            phase_d  = rarhdr_pkg::PH_M1;
            marker_d = pos_q;
          end else begin
            phase_d = rarhdr_pkg::PH_M0;
          end
        end
        rarhdr_pkg::PH_BODY4: begin
          if (rel_q == rarhdr_pkg::REL_FLAG_LO) begin
            flag_d = {flag_q[15:8], b};
          end else if (rel_q == rarhdr_pkg::REL_FLAG_HI) begin
            flag_d = {b, flag_q[7:0]};
          end
          if (rel_q >= rarhdr_pkg::REL_BODY4_END) begin
            em_valid  = 1'b1;
            em_status = rarhdr_pkg::ST_OK;
            em_ver    = rarhdr_pkg::VER_4;
          end
        end
        rarhdr_pkg::PH_BODY5: begin
          if ((rel_q >= rarhdr_pkg::REL_VARINT) && hfi_open) begin
            if (v_ovf) begin
              hfi_d = rarhdr_pkg::HF_INVALID;
            end else begin
              acc_lo_d = v_lo;
              acc_hi_d = v_hi;
              if (vidx_q != rarhdr_pkg::VIDX_MAX) begin
                vidx_d = vidx_q + 1'b1;
              end
              if (!b[7]) begin
                acc_lo_d = '0;
                acc_hi_d = 1'b0;
                vidx_d   = '0;
                unique case (hfi_q)
                  rarhdr_pkg::HF_SIZE: hfi_d = rarhdr_pkg::HF_TYPE;
                  rarhdr_pkg::HF_TYPE: begin
                    if (!v_hi && (v_lo == rarhdr_pkg::HDR_TYPE_MAIN)) begin
                      hfi_d = rarhdr_pkg::HF_HFLAGS;
                    end else if (!v_hi && (v_lo == rarhdr_pkg::HDR_TYPE_ENC)) begin
                      hfi_d = rarhdr_pkg::HF_ENC;
                    end else begin
                      hfi_d = rarhdr_pkg::HF_INVALID;
                    end
                  end
                  rarhdr_pkg::HF_HFLAGS: begin
                    hfi_d = v_lo[0] ? rarhdr_pkg::HF_EXTRA : rarhdr_pkg::HF_AFLAGS;
                  end
                  rarhdr_pkg::HF_EXTRA: hfi_d = rarhdr_pkg::HF_AFLAGS;
                  default: begin
                    flag_d = v_lo;
                    hfi_d  = rarhdr_pkg::HF_DONE;
                  end
                endcase
              end
            end
          end
          if (rel_q >= rarhdr_pkg::REL_BODY5_END) begin
            if (hfi_d == rarhdr_pkg::HF_DONE) begin
              em_valid  = 1'b1;
              em_status = rarhdr_pkg::ST_OK;
              em_ver    = rarhdr_pkg::VER_5;
            end else if ((hfi_d == rarhdr_pkg::HF_INVALID) ||
                         (hfi_d == rarhdr_pkg::HF_ENC)) begin
              em_valid  = 1'b1;
              em_status = (hfi_d == rarhdr_pkg::HF_ENC) ? rarhdr_pkg::ST_ENCRYPTED
                                                        : rarhdr_pkg::ST_INVALID;
              em_ver    = rarhdr_pkg::VER_5;
            end
          end
        end
        default: phase_d = rarhdr_pkg::PH_M0;
      endcase
    end

    // End of data: last byte, search window exhausted, or position saturated.
    if (!sent_q && !em_valid && (eof || limit_hit)) begin
      em_valid  = 1'b1;
      em_status = rarhdr_pkg::ST_INVALID;
      em_ver    = ((phase_d == rarhdr_pkg::PH_BODY5) && (rel_d >= rarhdr_pkg::REL_BODY5_FULL))
                  ? rarhdr_pkg::VER_5 : rarhdr_pkg::VER_NONE;
    end

    if (em_valid) begin
      sent_d = 1'b1;
    end
  end

  // Result fields
  always_comb begin
    res_o        = '0;
    res_o.status = em_status;
    res_o.version = em_ver;
    if (em_ver != rarhdr_pkg::VER_NONE) begin
      res_o.archive_offset     = marker_d;
      res_o.is_self_extracting = (marker_d != '0);
    end
    if ((em_status == rarhdr_pkg::ST_OK) && (em_ver == rarhdr_pkg::VER_4)) begin
      res_o.multivolume   = flag_d[0];
      res_o.locked        = flag_d[2];
      res_o.solid         = flag_d[3];
      res_o.has_recovery  = flag_d[6];
      res_o.hdr_encrypted = flag_d[7];
      res_o.first_vol     = flag_d[8];
    end else if ((em_status == rarhdr_pkg::ST_OK) && (em_ver == rarhdr_pkg::VER_5)) begin
      res_o.multivolume  = flag_d[0];
      res_o.locked       = flag_d[4];
      res_o.solid        = flag_d[2];
      res_o.has_recovery = flag_d[3];
      res_o.first_vol    = flag_d[0] && !flag_d[1];
    end
    // qualified by the input register valid at the top level
    res_valid_o = em_valid;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      msb_q <= rarhdr_pkg::MAX_SEARCH_RESET;
    end else if (cfg_we_i) begin
      msb_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= rarhdr_pkg::PH_M0;
      pos_q    <= '0;
      marker_q <= '0;
      flag_q   <= '0;
      acc_lo_q <= '0;
      acc_hi_q <= 1'b0;
      vidx_q   <= '0;
      hfi_q    <= rarhdr_pkg::HF_SIZE;
      rel_q    <= '0;
      sent_q   <= 1'b0;
    end else if (step_i) begin
      if (eof) begin
        // next file starts from scratch
        phase_q  <= rarhdr_pkg::PH_M0;
        pos_q    <= '0;
        marker_q <= '0;
        flag_q   <= '0;
        acc_lo_q <= '0;
        acc_hi_q <= 1'b0;
        vidx_q   <= '0;
        hfi_q    <= rarhdr_pkg::HF_SIZE;
        rel_q    <= '0;
        sent_q   <= 1'b0;
      end else begin
        phase_q  <= phase_d;
        pos_q    <= pos_d;
        marker_q <= marker_d;
        flag_q   <= flag_d;
        acc_lo_q <= acc_lo_d;
        acc_hi_q <= acc_hi_d;
        vidx_q   <= vidx_d;
        hfi_q    <= hfi_d;
        rel_q    <= rel_d;
        sent_q   <= sent_d;
      end
    end
  end

endmodule

// File: src/rarhdr_out_stage.sv
// Result register feeding the master stream.
module rarhdr_out_stage (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       load_i,
  input  rarhdr_pkg::rarhdr_result_t res_i,
  output logic                       free_o,
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  output logic [47:0]                m_axis_tdata_o
);

  logic                       valid_q, valid_d;
  rarhdr_pkg::rarhdr_result_t res_q;

  assign free_o = !valid_q || m_axis_tready_i;

  always_comb begin
    valid_d = valid_q;
    if (m_axis_tready_i) begin
      valid_d = 1'b0;
    end
    if (load_i) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = {{(rarhdr_pkg::OUT_DATA_W - rarhdr_pkg::OD_USED){1'b0}}, res_q};

endmodule

// File: src/rarhdr_checker.sv
// Port-level checks on the parser top level, bound to it.
module rarhdr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [47:0] m_axis_tdata_o
);

  // Stalled result transaction holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // With the output register empty, the input side never stalls.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled with empty output");

  a_codes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      (m_axis_tdata_o[rarhdr_pkg::OD_STATUS +: 2] != 2'd3) &&
      ((m_axis_tdata_o[rarhdr_pkg::OD_VER +: 3] == rarhdr_pkg::VER_NONE) ||
       (m_axis_tdata_o[rarhdr_pkg::OD_VER +: 3] == rarhdr_pkg::VER_4) ||
       (m_axis_tdata_o[rarhdr_pkg::OD_VER +: 3] == rarhdr_pkg::VER_5)))
    else $error("bad status or version code");

  // No marker means no offset.
  a_no_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tdata_o[rarhdr_pkg::OD_VER +: 3] == rarhdr_pkg::VER_NONE) |->
      (m_axis_tdata_o[rarhdr_pkg::OD_OFS +: 32] == 32'd0) &&
      !m_axis_tdata_o[rarhdr_pkg::OD_SFX])
    else $error("offset reported without marker");

  // Flags only accompany a successful parse.
  a_flags_ok_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tdata_o[rarhdr_pkg::OD_STATUS +: 2] != rarhdr_pkg::ST_OK) |->
      (m_axis_tdata_o[rarhdr_pkg::OD_FLAGS +: 6] == 6'd0))
    else $error("flags set on failed parse");

endmodule

bind rar_signature_and_main_header_parser rarhdr_checker u_checker (.*);

// File: tb/rar_signature_and_main_header_parser_test.sv
// Self-checking stream testbench for the archive signature and main header parser.
module rar_signature_and_main_header_parser_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rarhdr_pkg::*;

  localparam logic [47:0]      MARKER    = 48'h07_1A_21_72_61_52;  // first byte lowest
  localparam logic [POS_W-1:0] POS_LIMIT = '1;
  localparam int OFS_FLAG_LO = 10;
  localparam int OFS_FLAG_HI = 11;
  localparam int OFS_V4_LAST = 26;
  localparam int OFS_VARINT  = 12;
  localparam int OFS_V5_LAST = 15;
  localparam int OFS_V5_FULL = 16;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;

  rar_signature_and_main_header_parser u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // Parser mirror state
  logic [CFG_W-1:0]  search_limit = MAX_SEARCH_RESET;
  rarhdr_phase_e     scan_phase;
  logic [POS_W-1:0]  file_pos;
  logic [POS_W-1:0]  mark_pos;
  logic [2:0]        found_ver;
  logic [15:0]       flag_word;
  logic [63:0]       vacc;
  logic [3:0]        vidx;
  rarhdr_field_e     hfield;
  logic              has_extra;
  logic              reported;

  rarhdr_result_t    header_reports_q[$];
  rarhdr_item_t      byte_q[$];
  logic [7:0]        file_bytes[$];

  int errors = 0;
  int bytes_queued = 0;
  int bytes_taken = 0;
  int drv_gap_max = 8;
  int mon_gap_max = 8;
  int gap_left = 0;
  int stall_left = 0;
  bit took;
  rarhdr_item_t next_item;

  function automatic void clear_file();
    scan_phase = PH_M0;
    file_pos   = '0;
    mark_pos   = '0;
    found_ver  = VER_NONE;
    flag_word  = '0;
    vacc       = '0;
    vidx       = '0;
    hfield     = HF_SIZE;
    has_extra  = 1'b0;
    reported   = 1'b0;
  endfunction

  function automatic rarhdr_result_t make_result(logic [1:0] st, logic [2:0] ver, bit fl);
    rarhdr_result_t r;
    r = '0;
    r.status  = st;
    r.version = ver;
    if (ver != VER_NONE) begin
      r.archive_offset     = mark_pos;
      r.is_self_extracting = (mark_pos != '0);
    end
    if (fl && ver == VER_4) begin
      r.multivolume   = flag_word[0];
      r.locked        = flag_word[2];
      r.solid         = flag_word[3];
      r.has_recovery  = flag_word[6];
      r.hdr_encrypted = flag_word[7];
      r.first_vol     = flag_word[8];
    end else if (fl && ver == VER_5) begin
      r.multivolume  = flag_word[0];
      r.locked       = flag_word[4];
      r.solid        = flag_word[2];
      r.has_recovery = flag_word[3];
      r.first_vol    = flag_word[0] && !flag_word[1];
    end
    return r;
  endfunction

  function automatic void restart_scan(logic [7:0] b);
    if (b == MARKER[7:0]) begin
      scan_phase = PH_M1;
      mark_pos   = file_pos;
    end else begin
      scan_phase = PH_M0;
    end
  endfunction

  function automatic void close_field(logic [63:0] v);
    vacc = '0;
    vidx = '0;
    case (hfield)
      HF_SIZE: hfield = HF_TYPE;
      HF_TYPE: begin
        if (v == 64'(HDR_TYPE_MAIN)) hfield = HF_HFLAGS;
        else if (v == 64'(HDR_TYPE_ENC)) hfield = HF_ENC;
        else hfield = HF_INVALID;
      end
      HF_HFLAGS: begin
        has_extra = v[0];
        hfield = has_extra ? HF_EXTRA : HF_AFLAGS;
      end
      HF_EXTRA: hfield = HF_AFLAGS;
      default: begin
        flag_word = v[15:0];
        hfield = HF_DONE;
      end
    endcase
  endfunction

  function automatic void take_varint_byte(logic [7:0] b);
    logic [63:0] data;
    logic [63:0] sh;
    int shift;
    data  = {57'b0, b[6:0]};
    shift = int'(vidx) * 7;
    if (shift >= 64) begin
      if (data != '0) begin
        hfield = HF_INVALID;
        return;
      end
    end else begin
      sh = data << shift;
      if ((sh >> shift) != data) begin
        hfield = HF_INVALID;
        return;
      end
      vacc = vacc | sh;
    end
    if (vidx < VIDX_MAX) vidx = vidx + 1'b1;
    if (!b[7]) close_field(vacc);
  endfunction

  // Returns 1 when the byte fixes the outcome of the file.
  function automatic bit scan_byte(logic [7:0] b, output rarhdr_result_t res);
    logic [POS_W-1:0] rel;
    rel = file_pos - mark_pos;
    res = '0;
    if (scan_phase <= PH_M5) begin
      if (b == MARKER[8*int'(scan_phase) +: 8]) begin
        if (scan_phase == PH_M0) mark_pos = file_pos;
        scan_phase = rarhdr_phase_e'(scan_phase + 1);
      end else begin
        restart_scan(b);
      end
    end else if (scan_phase == PH_VER) begin
      if (b == VER_BYTE_4) begin
        scan_phase = PH_BODY4;
        found_ver  = VER_4;
        flag_word  = '0;
      end else if (b == VER_BYTE_5) begin
        scan_phase = PH_V5_ZERO;
      end else begin
        restart_scan(b);
      end
    end else if (scan_phase == PH_V5_ZERO) begin
      if (b == ZERO_BYTE) begin
        scan_phase = PH_BODY5;
        found_ver  = VER_5;
        hfield     = HF_SIZE;
        vacc       = '0;
        vidx       = '0;
      end else begin
        restart_scan(b);
      end
    end else if (scan_phase == PH_BODY4) begin
      if (rel == OFS_FLAG_LO) flag_word[7:0] = b;
      else if (rel == OFS_FLAG_HI) flag_word[15:8] = b;
      if (rel >= OFS_V4_LAST) begin
        res = make_result(ST_OK, VER_4, 1'b1);
        return 1'b1;
      end
    end else begin
      if (rel >= OFS_VARINT && hfield < HF_DONE) take_varint_byte(b);
      if (rel >= OFS_V5_LAST && hfield >= HF_DONE) begin
        if (hfield == HF_DONE) res = make_result(ST_OK, VER_5, 1'b1);
        else res = make_result(hfield == HF_ENC ? ST_ENCRYPTED : ST_INVALID, VER_5, 1'b0);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic void parse_file_byte(rarhdr_item_t it);
    rarhdr_result_t res;
    bit got;
    got = 1'b0;
    if (!reported) begin
      if (file_pos < search_limit && file_pos != POS_LIMIT) got = scan_byte(it.data_byte, res);
      if (file_pos != POS_LIMIT) file_pos = file_pos + 1'b1;
      if (!got && (it.end_of_file || file_pos >= search_limit || file_pos == POS_LIMIT)) begin
        got = 1'b1;
        if (scan_phase == PH_BODY5 && (file_pos - mark_pos) >= OFS_V5_FULL)
          res = make_result(ST_INVALID, VER_5, 1'b0);
        else
          res = make_result(ST_INVALID, VER_NONE, 1'b0);
      end
      if (got) begin
        reported = 1'b1;
        header_reports_q.push_back(res);
      end
    end
    if (it.end_of_file) clear_file();
  endfunction

  function automatic void cmp_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      errors++;
    end
  endfunction

  function automatic void check_report(logic [47:0] word);
    rarhdr_result_t want;
    rarhdr_result_t got;
    got = rarhdr_result_t'(word[43:0]);
    if (header_reports_q.size() == 0) begin
      $error("result transaction with none expected: %h", word);
      errors++;
      return;
    end
    want = header_reports_q.pop_front();
    cmp_field("status", 32'(want.status), 32'(got.status));
    cmp_field("version", 32'(want.version), 32'(got.version));
    cmp_field("archive_offset", want.archive_offset, got.archive_offset);
    cmp_field("is_self_extracting", 32'(want.is_self_extracting),
              32'(got.is_self_extracting));
    cmp_field("multivolume", 32'(want.multivolume), 32'(got.multivolume));
    cmp_field("locked", 32'(want.locked), 32'(got.locked));
    cmp_field("solid", 32'(want.solid), 32'(got.solid));
    cmp_field("has_recovery", 32'(want.has_recovery), 32'(got.has_recovery));
    cmp_field("hdr_encrypted", 32'(want.hdr_encrypted), 32'(got.hdr_encrypted));
    cmp_field("first_vol", 32'(want.first_vol), 32'(got.first_vol));
    cmp_field("pad", 32'd0, 32'(word[47:44]));
  endfunction

  // Byte driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      took = 1'b0;
      if (s_tvalid && s_tready) begin
        parse_file_byte(rarhdr_item_t'({s_tdata, s_tlast}));
        bytes_taken++;
        took = 1'b1;
        gap_left = $urandom_range(0, drv_gap_max);
      end
      if (!s_tvalid || took) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (byte_q.size() > 0) begin
          next_item = byte_q.pop_front();
          s_tdata  <= next_item.data_byte;
          s_tlast  <= next_item.end_of_file;
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_tvalid && m_tready) begin
        check_report(m_tdata);
        stall_left = $urandom_range(0, mon_gap_max);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      m_tready <= (stall_left == 0);
    end
  end

  // Stimulus helpers
  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 5))
      0: return MARKER[8*$urandom_range(0, 5) +: 8];
      1: return 8'($urandom_range(0, 1));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void put_marker();
    for (int i = 0; i < 6; i++) file_bytes.push_back(MARKER[8*i +: 8]);
  endfunction

  function automatic void put_varint(logic [63:0] v, int pad);
    logic [63:0] rest;
    rest = v;
    while (rest > 64'd127 || pad > 0) begin
      file_bytes.push_back({1'b1, rest[6:0]});
      if (rest > 64'd127) begin
        rest = rest >> 7;
      end else begin
        rest = '0;
        pad--;
      end
    end
    file_bytes.push_back({1'b0, rest[6:0]});
  endfunction

  // Integer too wide for 64 bits, or a legal one (all 64 bits set, or zero over eleven bytes)
  function automatic void put_wide_varint();
    if ($urandom_range(0, 1) == 0) begin
      repeat (9) file_bytes.push_back(8'hFF);
      file_bytes.push_back({1'b0, 7'($urandom_range(1, 127))});
    end else begin
      repeat (10) file_bytes.push_back(8'h80);
      file_bytes.push_back({1'b0, 7'($urandom_range(0, 3))});
    end
  endfunction

  function automatic int pick_pad();
    return ($urandom_range(0, 5) == 0) ? $urandom_range(1, 14) : 0;
  endfunction

  function automatic void flush_file();
    rarhdr_item_t it;
    for (int i = 0; i < file_bytes.size(); i++) begin
      it.data_byte   = file_bytes[i];
      it.end_of_file = (i == file_bytes.size() - 1);
      byte_q.push_back(it);
    end
    bytes_queued += file_bytes.size();
    file_bytes.delete();
  endfunction

  function automatic void gen_file();
    int kind;
    int cut;
    logic [63:0] hflags;
    logic [63:0] aflags;
    kind = $urandom_range(0, 9);
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 8)) file_bytes.push_back(noise_byte());
    case (kind)
      0, 1, 2: begin
        put_marker();
        file_bytes.push_back(VER_BYTE_4);
        repeat (20) file_bytes.push_back(8'($urandom_range(0, 255)));
      end
      3, 4, 5, 6: begin
        put_marker();
        file_bytes.push_back(VER_BYTE_5);
        file_bytes.push_back(ZERO_BYTE);
        repeat (4) file_bytes.push_back(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 9) == 0) put_wide_varint();
        else put_varint(64'($urandom_range(0, 300)), pick_pad());
        case ($urandom_range(0, 7))
          0: put_varint(64'(HDR_TYPE_ENC), pick_pad());
          1: put_varint(64'($urandom_range(0, 15)), 0);
          2: put_wide_varint();
          default: put_varint(64'(HDR_TYPE_MAIN), pick_pad());
        endcase
        hflags = 64'($urandom_range(0, 3));
        if ($urandom_range(0, 4) == 0) hflags = {$urandom(), $urandom()};
        put_varint(hflags, pick_pad());
        if (hflags[0]) put_varint(64'($urandom_range(0, 1000)), pick_pad());
        case ($urandom_range(0, 3))
          0: aflags = 64'($urandom_range(0, 16'hFFFF));
          1: aflags = {$urandom(), $urandom()};
          default: aflags = 64'($urandom_range(0, 31));
        endcase
        if ($urandom_range(0, 12) == 0) put_wide_varint();
        else put_varint(aflags, pick_pad());
      end
      7: begin
        cut = $urandom_range(1, 7);
        for (int i = 0; i < cut && i < 6; i++) file_bytes.push_back(MARKER[8*i +: 8]);
        if (cut == 7) file_bytes.push_back(VER_BYTE_5);
        file_bytes.push_back(noise_byte());
      end
      default: begin
        repeat ($urandom_range(1, 24)) file_bytes.push_back(noise_byte());
      end
    endcase
    repeat ($urandom_range(0, 4)) file_bytes.push_back(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 4) == 0) begin
      cut = $urandom_range(1, file_bytes.size());
      while (file_bytes.size() > cut) void'(file_bytes.pop_back());
    end
    flush_file();
  endfunction

  task automatic wait_idle();
    while (bytes_taken != bytes_queued || header_reports_q.size() != 0) @(posedge clk_i);
    // bytes past a result produce nothing; let the pipeline drain
    repeat (6) @(posedge clk_i);
  endtask

  task automatic set_search_limit(logic [31:0] v);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    search_limit = v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int files;
    int first_item;
    clear_file();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: minimal format 5 header with archive flags 0x1F at offset zero
    put_marker();
    file_bytes.push_back(VER_BYTE_5);
    file_bytes.push_back(ZERO_BYTE);
    repeat (4) file_bytes.push_back(8'h00);
    file_bytes.push_back(8'h05);
    file_bytes.push_back(8'h01);
    file_bytes.push_back(8'h00);
    file_bytes.push_back(8'h1F);
    flush_file();
    // single-byte files, byte extremes and a marker cut short
    file_bytes.push_back(8'hFF);
    flush_file();
    file_bytes.push_back(8'h00);
    flush_file();
    file_bytes.push_back(MARKER[7:0]);
    flush_file();
    for (int i = 0; i < 4; i++) file_bytes.push_back(MARKER[8*i +: 8]);
    flush_file();
    wait_idle();

    // Only the first byte is examined
    set_search_limit(32'd1);
    file_bytes.push_back(MARKER[7:0]);
    file_bytes.push_back(MARKER[15:8]);
    flush_file();
    repeat (3) gen_file();
    wait_idle();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          set_search_limit(32'hFFFF_FFFF);
          drv_gap_max = 8;
          mon_gap_max = 8;
        end
        1: begin
          set_search_limit($urandom_range(2, 40));
          drv_gap_max = 8;
          mon_gap_max = 0;
        end
        2: begin
          set_search_limit(MAX_SEARCH_RESET);
          drv_gap_max = 0;
          mon_gap_max = 0;
        end
        default: begin
          set_search_limit($urandom_range(16, 64));
          drv_gap_max = 0;
          mon_gap_max = 8;
        end
      endcase
      files = 0;
      first_item = bytes_queued;
      while (bytes_queued - first_item < 85 || files < 4) begin
        gen_file();
        files++;
      end
      wait_idle();
    end

    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
